// File: rtl/glcd_pkg.sv
// Shared codes and bus constants for the graphic LCD column write sequencer.
`timescale 1ns / 1ps
`default_nettype none

package glcd_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] REQ_COLUMN = 2'd0;
    localparam logic [1:0] REQ_ONOFF  = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    // Controller command opcodes
    localparam logic [7:0] CMD_ONOFF = 8'h3e;
    localparam logic [7:0] CMD_PAGE  = 8'hb8;
    localparam logic [7:0] CMD_COL   = 8'h40;
    localparam logic [7:0] CMD_START = 8'hc0;

    // Write slots within one item: page command, column command, payload
    localparam logic [1:0] SLOT_PAGE = 2'd0;
    localparam logic [1:0] SLOT_COL  = 2'd1;
    localparam logic [1:0] SLOT_DATA = 2'd2;

    // Strobe phases of one bus write: enable low, high, low
    localparam logic [1:0] PH_SETUP  = 2'd0;
    localparam logic [1:0] PH_STROBE = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;

    // Control word bit positions
    localparam int CTL_E_BIT   = 0;
    localparam int CTL_RW_BIT  = 1;
    localparam int CTL_RS_BIT  = 2;
    localparam int CTL_RES_BIT = 5;

    typedef logic [1:0] chip_sel_t;

endpackage

`default_nettype wire

// File: rtl/glcd_column_write_sequencer_unit.sv
// Top level: turns column and command requests into strobed LCD bus words.
//
//  channel   | dir | tdata (low bit up)                                  | tuser     | tlast
//  s_ (item) | in  | row 6, column 7, pixels 8, attr 2, run_start 1,     | req_type 2| -
//            |     | display_on 1, start_line 6, zero pad 1              |           |
//  m_ (word) | out | control 6, bus_data 8, zero pad 2                   | -         | last
//
// Each item gives 3 output words, or 9 for an addressed column write, one per
// cycle unless m_tready stalls, from the item register into the output register;
// the word count sets the rate at which items are taken.
// The next item is accepted in the cycle its predecessor's final word loads.
// A request of unused kind is accepted and dropped at once.
// Reset (aresetn low, synchronous) empties the item and output registers.
// A stall on m_tready holds the output word and freezes the word sequence.
`timescale 1ns / 1ps
`default_nettype none

module glcd_column_write_sequencer_unit
    import glcd_pkg::*;
#(
    parameter int HALF_WIDTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // row[5:0], column[12:6], pixels[20:13], attr[22:21], run_start[23],
    // display_on[24], start_line[30:25], zero[31]
    input  wire  [31:0] s_tdata,
    // req_type[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // control[5:0], bus_data[13:6], zero[15:14]
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    localparam logic [7:0] HALF_COL = 8'(HALF_WIDTH);

    // Unpack input beat
    logic [5:0] in_row;
    logic [6:0] in_column;
    logic [7:0] in_pixels;
    logic [1:0] in_attr;
    logic       in_run_start;
    logic       in_display_on;
    logic [5:0] in_start_line;

    assign in_row        = s_tdata[5:0];
    assign in_column     = s_tdata[12:6];
    assign in_pixels     = s_tdata[20:13];
    assign in_attr       = s_tdata[22:21];
    assign in_run_start  = s_tdata[23];
    assign in_display_on = s_tdata[24];
    assign in_start_line = s_tdata[30:25];

    // Item register: precomputed bytes and sequence position
    logic       busy_reg, busy_next;
    chip_sel_t  cs_reg, cs_next;
    logic       rs_reg, rs_next;
    logic       addressed_reg, addressed_next;
    logic [7:0] page_reg, page_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] dat_reg, dat_next;
    logic [1:0] slot_reg, slot_next;
    logic [1:0] ph_reg, ph_next;

    // Output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [13:0] m_word_reg, m_word_next;
    logic        m_tlast_reg, m_tlast_next;

    logic       out_free;
    logic       advance;
    logic       final_word;
    logic       accept;
    logic       take_item;
    logic       upper_half;
    logic [7:0] col_wide;
    logic [5:0] local_col;
    logic       force_addr;
    logic [7:0] word_byte;
    logic       word_rs;
    logic [5:0] word_ctl;

    // Handshake and sequencing conditions
    assign out_free   = !m_tvalid_reg || m_tready;
    assign advance    = busy_reg && out_free;
    assign final_word = (slot_reg == SLOT_DATA) && (ph_reg == PH_HOLD);
    assign s_tready   = !busy_reg || (advance && final_word);
    assign accept     = s_tvalid && s_tready;
    assign take_item  = accept && (s_tuser == REQ_COLUMN || s_tuser == REQ_ONOFF ||
                                   s_tuser == REQ_START);

    // Controller select and local column address
    assign col_wide   = {1'b0, in_column};
    assign upper_half = col_wide >= HALF_COL;
    assign local_col  = upper_half ? 6'(col_wide - HALF_COL) : in_column[5:0];
    assign force_addr = in_run_start || (col_wide == HALF_COL);

    // Select the byte and register select for the current write slot
    always_comb begin
        case (slot_reg)
            SLOT_PAGE: begin
                word_byte = page_reg;
                word_rs   = 1'b0;
            end
            SLOT_COL: begin
                word_byte = col_reg;
                word_rs   = 1'b0;
            end
            default: begin
                word_byte = dat_reg;
                word_rs   = rs_reg;
            end
        endcase
    end

    // Build control word: reset inactive, rw low, enable high in strobe phase
    always_comb begin
        word_ctl              = {1'b0, cs_reg, 3'b000};
        word_ctl[CTL_RES_BIT] = 1'b1;
        word_ctl[CTL_RS_BIT]  = word_rs;
        word_ctl[CTL_RW_BIT]  = 1'b0;
        word_ctl[CTL_E_BIT]   = (ph_reg == PH_STROBE);
    end

    // Next state of item register and output register
    always_comb begin
        busy_next      = busy_reg;
        cs_next        = cs_reg;
        rs_next        = rs_reg;
        addressed_next = addressed_reg;
        page_next      = page_reg;
        col_next       = col_reg;
        dat_next       = dat_reg;
        slot_next      = slot_reg;
        ph_next        = ph_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_word_next    = m_word_reg;
        m_tlast_next   = m_tlast_reg;

        // Drain the taken word
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Move one word into the output register and step the sequence
        if (advance) begin
            m_tvalid_next = 1'b1;
            m_word_next   = {word_byte, word_ctl};
            m_tlast_next  = final_word;
            if (final_word) begin
                busy_next = 1'b0;
            end else if (ph_reg == PH_HOLD) begin
                slot_next = slot_reg + 2'd1;
                ph_next   = PH_SETUP;
            end else begin
                ph_next = ph_reg + 2'd1;
            end
        end

        // Load a new item
        if (take_item) begin
            busy_next = 1'b1;
            ph_next   = PH_SETUP;
            page_next = CMD_PAGE | {5'b00000, in_row[5:3]};
            col_next  = CMD_COL | {2'b00, local_col};
            case (s_tuser)
                REQ_COLUMN: begin
                    cs_next        = upper_half ? 2'b10 : 2'b01;
                    rs_next        = 1'b1;
                    addressed_next = force_addr;
                    slot_next      = force_addr ? SLOT_PAGE : SLOT_DATA;
                    dat_next       = in_attr[1] ? 8'h00 :
                                     (in_attr[0] ? ~in_pixels : in_pixels);
                end
                REQ_ONOFF: begin
                    cs_next        = 2'b11;
                    rs_next        = 1'b0;
                    addressed_next = 1'b0;
                    slot_next      = SLOT_DATA;
                    dat_next       = CMD_ONOFF | {7'b0000000, in_display_on};
                end
                default: begin
                    cs_next        = 2'b11;
                    rs_next        = 1'b0;
                    addressed_next = 1'b0;
                    slot_next      = SLOT_DATA;
                    dat_next       = CMD_START | {2'b00, in_start_line};
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cs_reg        <= cs_next;
        rs_reg        <= rs_next;
        addressed_reg <= addressed_next;
        page_reg      <= page_next;
        col_reg       <= col_next;
        dat_reg       <= dat_next;
        slot_reg      <= slot_next;
        ph_reg        <= ph_next;
        m_word_reg    <= m_word_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_word_reg};
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // A kept item makes the sequencer busy on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        take_item |=> busy_reg)
        else $error("item accepted but sequencer not busy");

    // An unaddressed item only ever issues its payload write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !addressed_reg) |-> (slot_reg == SLOT_DATA))
        else $error("command words issued for unaddressed item");

    // The final word of an item ends its strobe with enable low
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tlast_reg) |-> !m_word_reg[CTL_E_BIT])
        else $error("last word with enable high");

    // Every word keeps reset inactive and rw low
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_word_reg[CTL_RES_BIT] && !m_word_reg[CTL_RW_BIT]))
        else $error("control word with bad reset or rw");

    // The sequence position never leaves its range while busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (slot_reg != 2'd3 && ph_reg != 2'd3))
        else $error("sequence position out of range");
`endif

endmodule

`default_nettype wire

// File: tb/sv/glcd_column_write_sequencer_unit_tb.sv
// Self-checking testbench for the graphic LCD column write sequencer.
`timescale 1ns / 1ps
`default_nettype none

module glcd_column_write_sequencer_unit_tb;
    import glcd_pkg::*;

    localparam int HALF_WIDTH     = 64;
    localparam int CHIP0_BIT      = 3;
    localparam int CHIP1_BIT      = 4;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // Unused request kind and pixel attributes
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam logic [1:0] ATTR_PLAIN   = 2'd0;
    localparam logic [1:0] ATTR_INVERT  = 2'd1;
    localparam logic [1:0] ATTR_CLEAR   = 2'd2;
    localparam logic [1:0] ATTR_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0] req;
        logic [5:0] row;
        logic [6:0] column;
        logic [7:0] pixels;
        logic [1:0] attr;
        logic       run_start;
        logic       display_on;
        logic [5:0] start_line;
    } lcd_item_t;

    typedef struct packed {
        logic [5:0] control;
        logic [7:0] bus_data;
        logic       last;
    } lcd_word_t;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata    = '0;
    logic [1:0]  s_tuser    = '0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    lcd_word_t   lcd_word_q[$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    bit          idle_en      = 1'b1;
    bit          rx_hold_req  = 1'b0;

    glcd_column_write_sequencer_unit #(
        .HALF_WIDTH(HALF_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Append the three strobe words of one bus write
    function automatic void queue_bus_write(chip_sel_t chips, logic rs, logic [7:0] data);
        lcd_word_t w;
        w.control = '0;
        w.control[CTL_RES_BIT] = 1'b1;
        w.control[CTL_RS_BIT]  = rs;
        w.control[CHIP0_BIT]   = chips[0];
        w.control[CHIP1_BIT]   = chips[1];
        w.bus_data = data;
        w.last     = 1'b0;
        lcd_word_q.push_back(w);
        w.control[CTL_E_BIT] = 1'b1;
        lcd_word_q.push_back(w);
        w.control[CTL_E_BIT] = 1'b0;
        lcd_word_q.push_back(w);
    endfunction

    // Work out the LCD bus words one accepted item causes
    function automatic void predict_lcd_words(lcd_item_t it);
        chip_sel_t  chips;
        logic [6:0] col_addr;
        logic [7:0] payload;
        case (it.req)
            REQ_COLUMN: begin
                if (it.column >= HALF_WIDTH) begin
                    chips    = 2'b10;
                    col_addr = 7'(it.column - HALF_WIDTH);
                end else begin
                    chips    = 2'b01;
                    col_addr = it.column;
                end
                if (it.run_start || it.column == HALF_WIDTH) begin
                    queue_bus_write(chips, 1'b0, CMD_PAGE | {5'b0, it.row[5:3]});
                    queue_bus_write(chips, 1'b0, CMD_COL | {2'b0, col_addr[5:0]});
                end
                if (it.attr[1])
                    payload = 8'h00;
                else if (it.attr[0])
                    payload = ~it.pixels;
                else
                    payload = it.pixels;
                queue_bus_write(chips, 1'b1, payload);
            end
            REQ_ONOFF: queue_bus_write(2'b11, 1'b0, CMD_ONOFF | {7'b0, it.display_on});
            REQ_START: queue_bus_write(2'b11, 1'b0, CMD_START | {2'b0, it.start_line});
            default: return;
        endcase
        lcd_word_q[lcd_word_q.size() - 1].last = 1'b1;
    endfunction

    // Offer one item at a falling edge, hold it until accepted
    task automatic send_item(lcd_item_t it);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req;
        s_tdata  <= {1'b0, it.start_line, it.display_on, it.run_start, it.attr,
                     it.pixels, it.column, it.row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_lcd_words(it);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every expected word has come out
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        wait (lcd_word_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic lcd_item_t make_column(logic [5:0] row, logic [6:0] column,
                                              logic [7:0] pixels, logic [1:0] attr,
                                              logic run_start);
        lcd_item_t it;
        it.req        = REQ_COLUMN;
        it.row        = row;
        it.column     = column;
        it.pixels     = pixels;
        it.attr       = attr;
        it.run_start  = run_start;
        it.display_on = 1'($urandom_range(0, 1));
        it.start_line = 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic lcd_item_t make_command(logic [1:0] req, logic on, logic [5:0] line);
        lcd_item_t it;
        it            = make_column(6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)),
                                    8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                                    1'($urandom_range(0, 1)));
        it.req        = req;
        it.display_on = on;
        it.start_line = line;
        return it;
    endfunction

    function automatic lcd_item_t make_noise();
        lcd_item_t it;
        it     = make_command(2'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              6'($urandom_range(0, 63)));
        it.req = 2'($urandom_range(0, 3));
        return it;
    endfunction

    // Display on/off and start line, both values at their extremes
    task automatic test_commands();
        send_item(make_command(REQ_ONOFF, 1'b0, 6'd0));
        send_item(make_command(REQ_ONOFF, 1'b1, 6'd63));
        send_item(make_command(REQ_START, 1'b1, 6'd0));
        send_item(make_command(REQ_START, 1'b0, 6'd63));
    endtask

    // Column writes at the edges of both controllers and every attribute
    task automatic test_column_edges();
        send_item(make_column(6'd0,  7'd0,   8'h00, ATTR_PLAIN,  1'b1));
        send_item(make_column(6'd0,  7'd1,   8'hff, ATTR_PLAIN,  1'b0));
        send_item(make_column(6'd63, 7'd63,  8'ha5, ATTR_INVERT, 1'b1));
        send_item(make_column(6'd63, 7'd64,  8'h5a, ATTR_PLAIN,  1'b0));
        send_item(make_column(6'd7,  7'd65,  8'hff, ATTR_INVERT, 1'b0));
        send_item(make_column(6'd8,  7'd127, 8'h3c, ATTR_CLEAR,  1'b1));
        send_item(make_column(6'd40, 7'd64,  8'hff, ATTR_UNUSED, 1'b1));
        send_item(make_column(6'd23, 7'd0,   8'h81, ATTR_UNUSED, 1'b0));
        send_item(make_column(6'd56, 7'd127, 8'h00, ATTR_INVERT, 1'b0));
        send_item(make_column(6'd31, 7'd62,  8'h7e, ATTR_CLEAR,  1'b0));
    endtask

    // Unused request kind: accepted, no words expected
    task automatic test_unused_request();
        send_item(make_command(REQ_UNUSED, 1'b1, 6'd63));
        send_item(make_command(REQ_ONOFF, 1'b1, 6'd17));
        send_item(make_command(REQ_UNUSED, 1'b0, 6'd0));
    endtask

    // Mostly bitmap runs with random content, plus commands and noise
    task automatic test_random_runs(int count);
        int         sent;
        int         run_len;
        logic [5:0] row;
        logic [6:0] column;
        lcd_item_t  it;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    run_len = $urandom_range(2, 8);
                    row     = 6'($urandom_range(0, 63));
                    column  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(58, 63))
                                                          : 7'($urandom_range(0, 127));
                    for (int i = 0; i < run_len; i++) begin
                        send_item(make_column(row, column, 8'($urandom_range(0, 255)),
                                              2'($urandom_range(0, 3)), i == 0));
                        column = column + 7'd1;
                        sent++;
                    end
                end
                7: begin
                    send_item(make_command(2'($urandom_range(1, 2)),
                                           1'($urandom_range(0, 1)),
                                           6'($urandom_range(0, 63))));
                    sent++;
                end
                8: begin
                    it = make_noise();
                    send_item(it);
                    if (it.req != REQ_UNUSED) sent++;
                end
                default: begin
                    // Broken run: continue without a run start at a random column
                    send_item(make_column(6'($urandom_range(0, 63)),
                                          7'($urandom_range(0, 127)),
                                          8'($urandom_range(0, 255)),
                                          2'($urandom_range(0, 3)),
                                          1'b0));
                    sent++;
                end
            endcase
        end
    endtask

    // Hold the receiver off while items keep coming so the input stalls
    task automatic test_output_backpressure();
        rx_hold_req = 1'b1;
        test_random_runs(30);
    endtask

    // Pause the sender until every word is out, then resume
    task automatic test_drain_pause();
        test_random_runs(15);
        drain_outputs();
        test_random_runs(15);
    endtask

    // Final stretch at full rate on both sides
    task automatic test_full_rate();
        idle_en = 1'b0;
        test_random_runs(40);
    endtask

    // Receiver ready: random stall bursts and one long hold on request
    always begin
        @(negedge aclk);
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            m_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge aclk);
            m_tready <= 1'b1;
        end else if (aresetn && idle_en && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
            m_tready <= 1'b1;
        end else begin
            m_tready <= aresetn;
        end
    end

    // Compare each output beat with the oldest expected word
    always @(posedge aclk) begin
        lcd_word_t got;
        lcd_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.control  = m_tdata[5:0];
            got.bus_data = m_tdata[13:6];
            got.last     = m_tlast;
            if (lcd_word_q.size() == 0) begin
                $error("unexpected beat: control %h bus_data %h last %b",
                       got.control, got.bus_data, got.last);
                mismatches++;
            end else begin
                want = lcd_word_q.pop_front();
                if (got.control !== want.control) begin
                    $error("control: expected %h, got %h", want.control, got.control);
                    mismatches++;
                end
                if (got.bus_data !== want.bus_data) begin
                    $error("bus_data: expected %h, got %h", want.bus_data, got.bus_data);
                    mismatches++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, got.last);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles without any beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_commands();
        test_column_edges();
        test_unused_request();
        test_random_runs(180);
        test_output_backpressure();
        test_drain_pause();
        test_full_rate();
        s_tvalid <= 1'b0;
        wait (lcd_word_q.size() == 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/glcd_pkg.sv
rtl/glcd_column_write_sequencer_unit.sv
tb/sv/glcd_column_write_sequencer_unit_tb.sv
